// ===== src/apfbd_pkg.sv =====
package apfbd_pkg;

  // Default build parameters of the detector.
  localparam int unsigned TIMER_BITS_DEF  = 16;
  localparam int unsigned MAX_SAMPLES_DEF = 63;

  // Fixed field widths.
  localparam int unsigned TGT_W   = 6;
  localparam int unsigned NUM_W   = 22;
  localparam int unsigned BAND_W  = 16;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned CMP_W   = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = NUM_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TARGET  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_NUMERATOR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH      = 8'd3;

  // Register reset values.
  localparam logic [TGT_W-1:0]  SAMPLE_TARGET_RST  = 6'd30;
  localparam logic [NUM_W-1:0]  FREQ_NUMERATOR_RST = 22'd99990;
  localparam logic [BAND_W-1:0] BAND_LOW_RST       = 16'd200;
  localparam logic [BAND_W-1:0] BAND_HIGH_RST      = 16'd260;

  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_SETUP_FREQ,
    ST_DIV_FREQ,
    ST_FINISH
  } state_e;

endpackage

// ===== src/averaged_period_frequency_band_detector_top.sv =====
// Averaged-period frequency band detector.
//
// The input stream carries one timer capture per rising edge of the measured
// signal. The first item of a burst only sets the reference time; each later
// item adds the wrapped edge-to-edge period to a running sum. When the number
// of periods reaches sample_target, a shared restoring divider first forms the
// mean period (sum / count) and then the frequency (freq_numerator / mean).
// One result item is then presented on the output stream with the band flags.
//
// Items that do not complete a measurement leave the block idle and ready for
// the next item. The item that completes one keeps the input not ready through
// the mean division, the setup state, the frequency division (skipped when the
// mean period is zero) and the finish state; its result item becomes valid as
// the block returns to idle. Each division runs one quotient bit per cycle through
// the single subtract-and-compare unit, DIV_W = max(TIMER_BITS + count bits, 22).
// The output register holds a result until the receiver takes it; a stalled
// receiver only holds the block in its final state once the next result is
// ready. Configuration writes are always taken and should be made while idle.
// Reset returns the registers to their defaults and the block to idle with no
// burst in progress and no result pending.
module averaged_period_frequency_band_detector_top
  import apfbd_pkg::*;
#(
  parameter int unsigned TIMER_BITS  = TIMER_BITS_DEF,
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int unsigned IN_W = ((TIMER_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,  // capture_time
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // mean_period, frequency
  output logic [1:0]            m_axis_tuser   // in_band, invalid_period
);

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = TIMER_BITS + CNT_W;
  localparam int unsigned DIV_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam logic [CMP_W-1:0] MAX_TGT = CMP_W'(MAX_SAMPLES);

  state_e state_q, state_d;

  logic [TGT_W-1:0]      sample_target_q, sample_target_d;
  logic [NUM_W-1:0]      freq_numerator_q, freq_numerator_d;
  logic [BAND_W-1:0]     band_low_q, band_low_d;
  logic [BAND_W-1:0]     band_high_q, band_high_d;

  logic [TIMER_BITS-1:0] last_capture_q, last_capture_d;
  logic                  collecting_q, collecting_d;
  logic [SUM_W-1:0]      period_sum_q, period_sum_d;
  logic [CNT_W-1:0]      period_count_q, period_count_d;

  logic [TIMER_BITS-1:0] rem_q, rem_d;
  logic [DIV_W-1:0]      quo_q, quo_d;
  logic [TIMER_BITS-1:0] divisor_q, divisor_d;
  logic [STEP_W-1:0]     step_q, step_d;

  logic [FIELD_W-1:0]    mean_out_q, mean_out_d;
  logic                  mean_zero_q, mean_zero_d;

  logic                  out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]    out_mean_q, out_mean_d;
  logic [FIELD_W-1:0]    out_freq_q, out_freq_d;
  logic                  out_in_band_q, out_in_band_d;
  logic                  out_invalid_q, out_invalid_d;

  logic                  in_fire;
  logic                  out_free;
  logic [TIMER_BITS-1:0] now;
  logic [TIMER_BITS-1:0] period;
  logic [SUM_W-1:0]      sum_new;
  logic [CNT_W-1:0]      count_new;
  logic [CMP_W-1:0]      target;
  logic                  burst_done;
  logic                  div_last;

  // Shared divider step.
  logic [TIMER_BITS:0]   rem_sh;
  logic                  rem_ge;
  logic [TIMER_BITS:0]   rem_sub;

  // Frequency result decode.
  logic                  freq_big;
  logic [FIELD_W-1:0]    freq_val;
  logic                  freq_invalid;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign now       = s_axis_tdata[TIMER_BITS-1:0];
  assign period    = now - last_capture_q;
  assign sum_new   = period_sum_q + SUM_W'(period);
  assign count_new = period_count_q + CNT_W'(1);

  always_comb begin
    target = CMP_W'(sample_target_q);
    if (target == '0) begin
      target = CMP_W'(1);
    end
    if (target > MAX_TGT) begin
      target = MAX_TGT;
    end
  end

  assign burst_done = collecting_q && (CMP_W'(count_new) >= target);
  assign div_last   = (step_q == STEP_W'(DIV_W - 1));

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor_q};
  assign rem_sub = rem_sh - {1'b0, divisor_q};

  assign freq_big     = |quo_q[DIV_W-1:FIELD_W];
  assign freq_val     = freq_big ? FIELD_MAX : quo_q[FIELD_W-1:0];
  assign freq_invalid = mean_zero_q || freq_big;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && burst_done) begin
          state_d = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_last) begin
          state_d = ST_SETUP_FREQ;
        end
      end
      ST_SETUP_FREQ: begin
        state_d = (quo_q == '0) ? ST_FINISH : ST_DIV_FREQ;
      end
      ST_DIV_FREQ: begin
        if (div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    sample_target_d  = sample_target_q;
    freq_numerator_d = freq_numerator_q;
    band_low_d       = band_low_q;
    band_high_d      = band_high_q;
    last_capture_d   = last_capture_q;
    collecting_d     = collecting_q;
    period_sum_d     = period_sum_q;
    period_count_d   = period_count_q;
    rem_d            = rem_q;
    quo_d            = quo_q;
    divisor_d        = divisor_q;
    step_d           = step_q;
    mean_out_d       = mean_out_q;
    mean_zero_d      = mean_zero_q;
    out_valid_d      = out_valid_q && !m_axis_tready;
    out_mean_d       = out_mean_q;
    out_freq_d       = out_freq_q;
    out_in_band_d    = out_in_band_q;
    out_invalid_d    = out_invalid_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SAMPLE_TARGET:  sample_target_d  = cfg_data_i[TGT_W-1:0];
        REG_FREQ_NUMERATOR: freq_numerator_d = cfg_data_i[NUM_W-1:0];
        REG_BAND_LOW:       band_low_d       = cfg_data_i[BAND_W-1:0];
        REG_BAND_HIGH:      band_high_d      = cfg_data_i[BAND_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q) inside
      ST_IDLE: begin
        if (in_fire) begin
          last_capture_d = now;
          if (!collecting_q) begin
            collecting_d   = 1'b1;
            period_sum_d   = '0;
            period_count_d = '0;
          end else if (burst_done) begin
            collecting_d   = 1'b0;
            period_sum_d   = '0;
            period_count_d = '0;
            rem_d          = '0;
            quo_d          = DIV_W'(sum_new);
            divisor_d      = TIMER_BITS'(count_new);
            step_d         = '0;
          end else begin
            period_sum_d   = sum_new;
            period_count_d = count_new;
          end
        end
      end
      ST_DIV_MEAN, ST_DIV_FREQ: begin
        rem_d  = rem_ge ? rem_sub[TIMER_BITS-1:0] : rem_sh[TIMER_BITS-1:0];
        quo_d  = {quo_q[DIV_W-2:0], rem_ge};
        step_d = step_q + STEP_W'(1);
      end
      ST_SETUP_FREQ: begin
        // The mean fits the timer width, since every period does.
        mean_out_d  = freq_big ? FIELD_MAX : quo_q[FIELD_W-1:0];
        mean_zero_d = (quo_q == '0);
        divisor_d   = quo_q[TIMER_BITS-1:0];
        rem_d       = '0;
        quo_d       = DIV_W'(freq_numerator_q);
        step_d      = '0;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_mean_d    = mean_out_q;
          out_freq_d    = mean_zero_q ? FIELD_MAX : freq_val;
          out_invalid_d = freq_invalid;
          out_in_band_d = !freq_invalid && (freq_val > band_low_q)
                          && (freq_val < band_high_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      sample_target_q  <= SAMPLE_TARGET_RST;
      freq_numerator_q <= FREQ_NUMERATOR_RST;
      band_low_q       <= BAND_LOW_RST;
      band_high_q      <= BAND_HIGH_RST;
      last_capture_q   <= '0;
      collecting_q     <= 1'b0;
      period_sum_q     <= '0;
      period_count_q   <= '0;
      step_q           <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      sample_target_q  <= sample_target_d;
      freq_numerator_q <= freq_numerator_d;
      band_low_q       <= band_low_d;
      band_high_q      <= band_high_d;
      last_capture_q   <= last_capture_d;
      collecting_q     <= collecting_d;
      period_sum_q     <= period_sum_d;
      period_count_q   <= period_count_d;
      step_q           <= step_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    quo_q         <= quo_d;
    divisor_q     <= divisor_d;
    mean_out_q    <= mean_out_d;
    mean_zero_q   <= mean_zero_d;
    out_mean_q    <= out_mean_d;
    out_freq_q    <= out_freq_d;
    out_in_band_q <= out_in_band_d;
    out_invalid_q <= out_invalid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_freq_q, out_mean_q};
  assign m_axis_tuser  = {out_invalid_q, out_in_band_q};

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("in_band and invalid_period both set");

  a_invalid_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[31:16] == FIELD_MAX))
    else $error("invalid result without saturated frequency");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(period_count_q) < MAX_TGT)
    else $error("period count reached the sample limit without finishing");

  a_div_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_MEAN || state_q == ST_DIV_FREQ) |-> (step_q < STEP_W'(DIV_W)))
    else $error("divider ran past its last step");
`endif

endmodule
